>>> design/crbe_pkg.sv
// ----------------------------------------------------------------------------
// crbe_pkg
// Shared codes, pixel constants and the clip result type of the blitter.
// ----------------------------------------------------------------------------
package crbe_pkg;

  localparam logic [2:0] FN_FILL   = 3'd0;
  localparam logic [2:0] FN_COPY   = 3'd1;
  localparam logic [2:0] FN_INVERT = 3'd2;
  localparam logic [2:0] FN_THRESH = 3'd3;
  localparam logic [2:0] FN_SWAP   = 3'd4;
  localparam logic [2:0] FN_SETPX  = 3'd5;
  localparam logic [2:0] FN_READPX = 3'd6;
  localparam logic [2:0] FN_RSVD   = 3'd7;

  localparam logic [31:0] PIX_WHITE = 32'hFFFF_FFFF;
  localparam logic [31:0] PIX_BLACK = 32'h00FF_FFFF;
  localparam logic [31:0] LOW3_MASK = 32'h00FF_FFFF;

  typedef struct packed {
    logic       ok;
    logic [9:0] dx;
    logic [9:0] dy;
    logic [9:0] sx;
    logic [9:0] sy;
    logic [9:0] w;
    logic [9:0] h;
  } crbe_clip_t;

endpackage

>>> design/clipped_rect_blit_engine.sv
// ----------------------------------------------------------------------------
// clipped_rect_blit_engine
// Rectangle blitter with clipping over SURFACES frame surfaces.
// ----------------------------------------------------------------------------
// Usage: a command beat on the in channel (valid/ready) carries the function,
// surfaces, origins, size and operands. The block clips the rectangle, walks
// it in raster order through the frame RAM and returns one result beat on the
// out channel with the read value, clipped size and a performed flag.
// Per pixel, fill and set pixel write once; invert, threshold and read pixel
// read then write (read pixel writes nothing); swap reads both pixels and
// writes both back. The frame RAM is simple dual-port (one read, one write per
// cycle, registered read); copy stages each row through a line buffer. One
// command is worked at a time.
// After reset a clearing pass writes BLACK to every word, with in_ready_o low
// throughout.
// When the receiver stalls the result stays in the output register; the next
// command is still taken and worked, and holds at its end until that
// register is free.
// ----------------------------------------------------------------------------
module clipped_rect_blit_engine #(
  parameter int COLS     = 256,
  parameter int ROWS     = 256,
  parameter int SURFACES = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic        dst_surface_i,
  input  logic        src_surface_i,
  input  logic signed [9:0] dst_x_i,
  input  logic signed [9:0] dst_y_i,
  input  logic signed [9:0] src_x_i,
  input  logic signed [9:0] src_y_i,
  input  logic signed [9:0] width_i,
  input  logic signed [9:0] height_i,
  input  logic [31:0] fill_value_i,
  input  logic [8:0]  threshold_q8_i,
  input  logic        pixel_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic [9:0]  clipped_width_o,
  output logic [9:0]  clipped_height_o,
  output logic        performed_o
);
  import crbe_pkg::*;

  localparam int PLANE = ROWS * COLS;
  localparam int DEPTH = SURFACES * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(COLS);
  localparam int YW    = $clog2(ROWS);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_RD2   = 4'd4;
  localparam logic [3:0] ST_WR    = 4'd5;
  localparam logic [3:0] ST_WR2   = 4'd6;
  localparam logic [3:0] ST_CRD   = 4'd7;
  localparam logic [3:0] ST_CCAP  = 4'd8;
  localparam logic [3:0] ST_CLB   = 4'd9;
  localparam logic [3:0] ST_CWR   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [XW-1:0] xcnt_q, xcnt_d;
  logic [YW-1:0] ycnt_q, ycnt_d;
  logic [AW-1:0] dst_row_q, dst_row_d, src_row_q, src_row_d;
  logic          out_valid_q, out_valid_d;

  logic [2:0]    func_q;
  logic          ds_q, ss_q;
  logic [31:0]   fill_q, sp_q, tp_q, rd_q;
  logic [8:0]    thr_q;
  logic          on_q;
  crbe_clip_t    clip_q, clip_c;
  logic [31:0]   read_value_q;
  logic [9:0]    cw_q, ch_q;
  logic          perf_q;

  logic          in_acc;
  logic          f_we;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [31:0]   f_wdata, f_rdata;
  logic          lb_we;
  logic [31:0]   lb_rdata;
  logic [AW-1:0] dst_a, src_a;
  logic          x_last, y_last;
  logic [3:0]    px_start;
  logic [9:0]    total;
  logic [31:0]   thr_px;

  crbe_clip #(.COLS(COLS), .ROWS(ROWS)) u_clip (
    .func_i   (func_i),
    .dst_x_i  (dst_x_i),
    .dst_y_i  (dst_y_i),
    .src_x_i  (src_x_i),
    .src_y_i  (src_y_i),
    .width_i  (width_i),
    .height_i (height_i),
    .clip_o   (clip_c)
  );

  crbe_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_frame (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  crbe_ram #(.DEPTH(COLS), .WIDTH(32)) u_line (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (xcnt_q),
    .wdata_i (f_rdata),
    .raddr_i (xcnt_q),
    .rdata_o (lb_rdata)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign read_value_o     = read_value_q;
  assign clipped_width_o  = cw_q;
  assign clipped_height_o = ch_q;
  assign performed_o      = perf_q;

  assign dst_a  = dst_row_q + AW'(clip_q.dx) + AW'(xcnt_q);
  assign src_a  = src_row_q + AW'(clip_q.sx) + AW'(xcnt_q);
  // a full extent of COLS (256) is masked to zero in XW bits; size minus one still fits
  assign x_last = xcnt_q == XW'(clip_q.w - 10'd1);
  assign y_last = ycnt_q == YW'(clip_q.h - 10'd1);

  assign total  = 10'(f_rdata[7:0]) + 10'(f_rdata[15:8]) + 10'(f_rdata[23:16]);
  assign thr_px = ({1'b0, total, 8'd0} > (19'd765 * 19'(thr_q))) ? PIX_WHITE : PIX_BLACK;

  always_comb begin
    case (func_q)
      FN_FILL, FN_SETPX: px_start = ST_WR;
      FN_COPY:           px_start = ST_CRD;
      default:           px_start = ST_RD;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    xcnt_d      = xcnt_q;
    ycnt_d      = ycnt_q;
    dst_row_d   = dst_row_q;
    src_row_d   = src_row_q;
    out_valid_d = out_valid_q;
    f_we        = 1'b0;
    f_waddr     = dst_a;
    f_wdata     = fill_q;
    f_raddr     = src_a;
    lb_we       = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_q;
        f_wdata = PIX_BLACK;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_START;
      end
      ST_START: begin
        xcnt_d    = '0;
        ycnt_d    = '0;
        dst_row_d = AW'(ds_q) * AW'(PLANE) + AW'(clip_q.dy) * AW'(COLS);
        src_row_d = AW'(ss_q) * AW'(PLANE) + AW'(clip_q.sy) * AW'(COLS);
        state_d   = clip_q.ok ? px_start : ST_DONE;
      end
      ST_RD: begin
        f_raddr = (func_q == FN_READPX) ? dst_a : src_a;
        state_d = (func_q == FN_SWAP) ? ST_RD2 : ST_WR;
      end
      ST_RD2: begin
        f_raddr = dst_a;
        state_d = ST_WR;
      end
      ST_WR: begin
        f_we = (func_q != FN_READPX);
        case (func_q)
          FN_SETPX:  f_wdata = on_q ? PIX_WHITE : PIX_BLACK;
          FN_INVERT: f_wdata = f_rdata ^ LOW3_MASK;
          FN_THRESH: f_wdata = thr_px;
          FN_SWAP:   f_wdata = sp_q;
          default:   f_wdata = fill_q;
        endcase
        state_d = (func_q == FN_SWAP) ? ST_WR2 : px_start;
      end
      ST_WR2: begin
        f_we    = 1'b1;
        f_waddr = src_a;
        f_wdata = tp_q;
        state_d = ST_RD;
      end
      ST_CRD: begin
        f_raddr = src_a;
        state_d = ST_CCAP;
      end
      ST_CCAP: begin
        lb_we = 1'b1;
        if (x_last) begin
          xcnt_d  = '0;
          state_d = ST_CLB;
        end else begin
          xcnt_d  = xcnt_q + XW'(1);
          state_d = ST_CRD;
        end
      end
      ST_CLB: begin
        state_d = ST_CWR;
      end
      ST_CWR: begin
        f_we    = 1'b1;
        f_wdata = lb_rdata;
        state_d = ST_CLB;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // advance the raster position after the last access of a pixel
    if ((state_q == ST_WR && func_q != FN_SWAP) || state_q == ST_WR2 ||
        state_q == ST_CWR) begin
      if (x_last) begin
        xcnt_d = '0;
        if (y_last) begin
          state_d = ST_DONE;
        end else begin
          ycnt_d    = ycnt_q + YW'(1);
          dst_row_d = dst_row_q + AW'(COLS);
          src_row_d = src_row_q + AW'(COLS);
          state_d   = px_start;
        end
      end else begin
        xcnt_d = xcnt_q + XW'(1);
        if (state_q == ST_CWR) state_d = ST_CLB;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      xcnt_q      <= '0;
      ycnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      xcnt_q      <= xcnt_d;
      ycnt_q      <= ycnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_row_q <= dst_row_d;
    src_row_q <= src_row_d;
    if (in_acc) begin
      func_q <= func_i;
      ds_q   <= (SURFACES > 1) ? dst_surface_i : 1'b0;
      ss_q   <= (SURFACES > 1) ? src_surface_i : 1'b0;
      fill_q <= fill_value_i;
      thr_q  <= threshold_q8_i;
      on_q   <= pixel_on_i;
      clip_q <= clip_c;
    end
    if (state_q == ST_START) rd_q <= '0;
    if (state_q == ST_WR && func_q == FN_READPX) rd_q <= f_rdata;
    if (state_q == ST_RD2) sp_q <= f_rdata;
    if (state_q == ST_WR) tp_q <= f_rdata;
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      read_value_q <= rd_q;
      cw_q         <= clip_q.w;
      ch_q         <= clip_q.h;
      perf_q       <= clip_q.ok;
    end
  end

`ifndef ASSERT_OFF
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("command taken during clearing pass");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside done state");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR2) |-> ($past(state_q) == ST_WR && func_q == FN_SWAP))
    else $error("swap write-back out of order");

  a_copy_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWR) |-> (xcnt_q <= XW'(clip_q.w - 10'd1)))
    else $error("copy column beyond clipped width");
`endif

endmodule

>>> design/crbe_ram.sv
// ----------------------------------------------------------------------------
// crbe_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crbe_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/crbe_clip.sv
// ----------------------------------------------------------------------------
// crbe_clip
// Clips a command rectangle against the surface edges; a set or read pixel is checked to lie inside.
// ----------------------------------------------------------------------------
module crbe_clip #(
  parameter int COLS = 256,
  parameter int ROWS = 256
) (
  input  logic              [2:0] func_i,
  input  logic signed       [9:0] dst_x_i,
  input  logic signed       [9:0] dst_y_i,
  input  logic signed       [9:0] src_x_i,
  input  logic signed       [9:0] src_y_i,
  input  logic signed       [9:0] width_i,
  input  logic signed       [9:0] height_i,
  output crbe_pkg::crbe_clip_t    clip_o
);
  import crbe_pkg::*;

  localparam logic signed [11:0] COLS_S = 12'(COLS);
  localparam logic signed [11:0] ROWS_S = 12'(ROWS);

  logic               use_src;
  logic               rect_op;
  logic signed [11:0] dx, dy, sx, sy, w, h;
  logic signed [11:0] dxc, dyc, sxc, syc;
  logic signed [11:0] w1, h1, wf, hf, wm, hm;
  logic               px_in;

  always_comb begin
    dx = {{2{dst_x_i[9]}}, dst_x_i};
    dy = {{2{dst_y_i[9]}}, dst_y_i};
    sx = {{2{src_x_i[9]}}, src_x_i};
    sy = {{2{src_y_i[9]}}, src_y_i};
    w  = {{2{width_i[9]}}, width_i};
    h  = {{2{height_i[9]}}, height_i};

    use_src = (func_i inside {FN_COPY, FN_INVERT, FN_THRESH, FN_SWAP});
    rect_op = use_src || (func_i == FN_FILL);

    dxc = dx[11] ? 12'sd0 : dx;
    dyc = dy[11] ? 12'sd0 : dy;
    sxc = sx[11] ? 12'sd0 : sx;
    syc = sy[11] ? 12'sd0 : sy;

    // negative origins eat into the size
    w1 = w + (dx[11] ? dx : 12'sd0) + ((use_src && sx[11]) ? sx : 12'sd0);
    h1 = h + (dy[11] ? dy : 12'sd0) + ((use_src && sy[11]) ? sy : 12'sd0);
    wf = w1[11] ? COLS_S : w1;
    hf = h1[11] ? ROWS_S : h1;

    wm = (wf < COLS_S - dxc) ? wf : COLS_S - dxc;
    hm = (hf < ROWS_S - dyc) ? hf : ROWS_S - dyc;
    if (use_src) begin
      if (COLS_S - sxc < wm) wm = COLS_S - sxc;
      if (ROWS_S - syc < hm) hm = ROWS_S - syc;
    end

    px_in = !dx[11] && (dx < COLS_S) && !dy[11] && (dy < ROWS_S);

    clip_o = '0;
    if (rect_op) begin
      if (wm > 12'sd0 && hm > 12'sd0) begin
        clip_o.ok = 1'b1;
        clip_o.dx = dxc[9:0];
        clip_o.dy = dyc[9:0];
        clip_o.sx = sxc[9:0];
        clip_o.sy = syc[9:0];
        clip_o.w  = wm[9:0];
        clip_o.h  = hm[9:0];
      end
    end else if ((func_i == FN_SETPX || func_i == FN_READPX) && px_in) begin
      clip_o.ok = 1'b1;
      clip_o.dx = dst_x_i;
      clip_o.dy = dst_y_i;
      clip_o.w  = 10'd1;
      clip_o.h  = 10'd1;
    end
  end

endmodule
